// ----- rtl/sdg_pkg.sv -----
// Shared types and constants for the step/dir pulse generator.
package sdg_pkg;

  localparam int unsigned POSITION_BITS_DEFAULT = 32;
  localparam int unsigned PERIOD_W              = 16;
  localparam int unsigned CMD_W                 = 3;
  localparam int unsigned TARGET_W              = 31;
  localparam int unsigned OUT_POS_W             = 32;
  localparam int unsigned IN_TDATA_W            = 32;
  localparam int unsigned OUT_TDATA_W           = 40;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_MOVE    = 3'd1,
    CMD_SPIN    = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_SET_POS = 3'd4
  } sdg_cmd_e;

  typedef struct packed {
    logic step_level;
    logic negative_dir;
    logic move_active;
    logic spin_active;
    logic pending_valid;
  } sdg_flags_t;

endpackage

// ----- rtl/sdg_step_logic.sv -----
// Next-state logic of the step/dir generator for one command transaction.
module sdg_step_logic #(
  parameter int unsigned PositionBits = sdg_pkg::POSITION_BITS_DEFAULT
) (
  input  logic [sdg_pkg::CMD_W-1:0]      cmd_i,
  input  logic [sdg_pkg::TARGET_W-1:0]   target_i,
  input  logic                           spin_negative_i,
  input  logic [sdg_pkg::PERIOD_W-1:0]   period_i,
  input  logic [sdg_pkg::PERIOD_W-1:0]   tick_q_i,
  input  logic signed [PositionBits-1:0] pos_q_i,
  input  logic signed [PositionBits-1:0] tgt_q_i,
  input  logic signed [PositionBits-1:0] pend_tgt_q_i,
  input  sdg_pkg::sdg_flags_t            flags_q_i,
  output logic [sdg_pkg::PERIOD_W-1:0]   tick_d_o,
  output logic signed [PositionBits-1:0] pos_d_o,
  output logic signed [PositionBits-1:0] tgt_d_o,
  output logic signed [PositionBits-1:0] pend_tgt_d_o,
  output sdg_pkg::sdg_flags_t            flags_d_o,
  output logic                           reached_o
);
  import sdg_pkg::*;

  localparam logic [PositionBits-1:0] PosOne = {{(PositionBits-1){1'b0}}, 1'b1};

  logic [63:0]                    target_ext;
  logic signed [PositionBits-1:0] half_target;
  logic [PERIOD_W-1:0]            tick_inc;
  logic                           start;
  logic signed [PositionBits-1:0] start_tgt;

  assign target_ext  = 64'(signed'(target_i));
  assign half_target = {target_ext[PositionBits-2:0], 1'b0};
  assign tick_inc    = tick_q_i + PERIOD_W'(1);

  always_comb begin
    tick_d_o     = tick_q_i;
    pos_d_o      = pos_q_i;
    tgt_d_o      = tgt_q_i;
    pend_tgt_d_o = pend_tgt_q_i;
    flags_d_o    = flags_q_i;
    reached_o    = 1'b0;
    start        = 1'b0;
    start_tgt    = half_target;
    case (sdg_cmd_e'(cmd_i))
      CMD_TICK: begin
        if (flags_q_i.move_active || flags_q_i.spin_active) begin
          if (tick_inc == period_i) begin
            tick_d_o = '0;
            if (flags_q_i.spin_active) begin
              flags_d_o.step_level = ~flags_q_i.step_level;
            end else if (pos_q_i != tgt_q_i) begin
              flags_d_o.negative_dir = (tgt_q_i < pos_q_i);
              flags_d_o.step_level   = ~flags_q_i.step_level;
              pos_d_o = (tgt_q_i < pos_q_i) ? pos_q_i - PosOne : pos_q_i + PosOne;
            end else begin
              flags_d_o.move_active = 1'b0;
              flags_d_o.spin_active = 1'b0;
              reached_o             = 1'b1;
              if (flags_q_i.pending_valid) begin
                flags_d_o.pending_valid = 1'b0;
                start     = 1'b1;
                start_tgt = pend_tgt_q_i;
              end
            end
          end else begin
            tick_d_o = tick_inc;
          end
        end
      end
      CMD_MOVE: begin
        if (!flags_q_i.spin_active) begin
          if (flags_q_i.move_active) begin
            flags_d_o.pending_valid = 1'b1;
            pend_tgt_d_o            = half_target;
          end else begin
            start = 1'b1;
          end
        end
      end
      CMD_SPIN: begin
        flags_d_o.negative_dir = spin_negative_i;
        flags_d_o.spin_active  = 1'b1;
      end
      CMD_STOP: begin
        flags_d_o.move_active = 1'b0;
        flags_d_o.spin_active = 1'b0;
        tick_d_o              = '0;
      end
      CMD_SET_POS: begin
        pos_d_o = half_target;
      end
      default: begin
      end
    endcase
    if (start) begin
      tick_d_o = '0;
      tgt_d_o  = start_tgt;
      if (start_tgt < pos_q_i) begin
        flags_d_o.negative_dir = 1'b1;
      end else if (pos_q_i < start_tgt) begin
        flags_d_o.negative_dir = 1'b0;
      end
      flags_d_o.move_active = 1'b1;
    end
  end

endmodule

// ----- rtl/stepper_step_dir_generator_unit.sv -----
// Top level of the step/dir pulse generator: state, config and output registers.
//
// channel   direction  contents
// s_axis    in         command transaction: tuser cmd, tdata target / spin_negative
// m_axis    out        status transaction: pin levels, flags, position, reached
// cfg       in         period_ticks write, always ready
//
// One transaction per clock while s_axis_tready is high; the result is registered
// and appears in the cycle after acceptance. The output register holds a result until m_axis_tready; s_axis_tready is
// high when that register is empty or being drained in the same cycle.
// Reset clears all state but the output data register, period_ticks returns to 1.
module stepper_step_dir_generator_unit #(
  parameter int unsigned PositionBits = sdg_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [30:0] target, [31] spin_negative
  input  logic [sdg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [2:0] cmd
  input  logic [sdg_pkg::CMD_W-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] step_level, [1] dir_level, [2] moving, [3] spinning,
  // [35:4] position, [36] reached, [39:37] zero
  output logic [sdg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sdg_pkg::PERIOD_W-1:0]        cfg_data_i
);
  import sdg_pkg::*;

  logic [PERIOD_W-1:0]            period_q;
  logic [PERIOD_W-1:0]            tick_q, tick_d;
  logic signed [PositionBits-1:0] pos_q, pos_d;
  logic signed [PositionBits-1:0] tgt_q, tgt_d;
  logic signed [PositionBits-1:0] pend_tgt_q, pend_tgt_d;
  sdg_flags_t                     flags_q, flags_d;
  logic                           reached;
  logic                           in_fire;
  logic                           out_valid_q;
  logic [OUT_TDATA_W-1:0]         out_data_q;
  logic [63:0]                    pos_ext;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign pos_ext       = 64'(pos_d);

  sdg_step_logic #(
    .PositionBits(PositionBits)
  ) u_step (
    .cmd_i          (s_axis_tuser),
    .target_i       (s_axis_tdata[TARGET_W-1:0]),
    .spin_negative_i(s_axis_tdata[TARGET_W]),
    .period_i       (period_q),
    .tick_q_i       (tick_q),
    .pos_q_i        (pos_q),
    .tgt_q_i        (tgt_q),
    .pend_tgt_q_i   (pend_tgt_q),
    .flags_q_i      (flags_q),
    .tick_d_o       (tick_d),
    .pos_d_o        (pos_d),
    .tgt_d_o        (tgt_d),
    .pend_tgt_d_o   (pend_tgt_d),
    .flags_d_o      (flags_d),
    .reached_o      (reached)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (cfg_valid_i) begin
      period_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      pos_q      <= '0;
      tgt_q      <= '0;
      pend_tgt_q <= '0;
      flags_q    <= '0;
    end else if (in_fire) begin
      tick_q     <= tick_d;
      pos_q      <= pos_d;
      tgt_q      <= tgt_d;
      pend_tgt_q <= pend_tgt_d;
      flags_q    <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {3'b000, reached, pos_ext[OUT_POS_W-1:0], flags_d.spin_active,
                     flags_d.move_active, flags_d.negative_dir, flags_d.step_level};
    end
  end

endmodule
